// ===== sv/humidity_temp_frame_decoder_defines.svh =====
// assertion macros for the measurement frame decoder checker
// no dependencies; included by the checker file
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, reset low disables
`define HTFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htfd assertion failed");

// next-cycle implication, reset low disables
`define HTFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htfd assertion failed");

`endif

// ===== sv/htfd_pkg.sv =====
// constants, widths and helper functions for the measurement frame decoder
// no dependencies; used by the top level and its checker
package htfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CENTI_W  = 15;
  localparam int unsigned PROD_W   = 31;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [BYTE_W-1:0]  CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0]  CRC_INIT = 8'hFF;
  localparam logic [WORD_W-1:0]  TEMP_SPAN    = 16'd17500;
  localparam logic [WORD_W-1:0]  HUMID_SPAN   = 16'd12500;
  localparam logic [WORD_W-1:0]  TEMP_OFFSET  = 16'd4500;
  localparam logic [WORD_W-1:0]  HUMID_OFFSET = 16'd600;

  localparam int TEMP_CENTI_MIN  = -4500;
  localparam int TEMP_CENTI_MAX  = 13000;
  localparam int HUMID_CENTI_MIN = -600;
  localparam int HUMID_CENTI_MAX = 11900;

  // result beat field positions
  localparam int unsigned TC_LSB = 0;
  localparam int unsigned HC_LSB = TC_LSB + CENTI_W;
  localparam int unsigned TR_LSB = HC_LSB + CENTI_W;
  localparam int unsigned HR_LSB = TR_LSB + WORD_W;
  localparam int unsigned TP_BIT = HR_LSB + WORD_W;
  localparam int unsigned HP_BIT = TP_BIT + 1;
  localparam int unsigned FV_BIT = HP_BIT + 1;

  // crc-8, msb first, no final xor
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      v = v[BYTE_W-1] ? ({v[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {v[BYTE_W-2:0], 1'b0};
    end
    return v;
  endfunction

  // floor(prod / 65535) minus offset, kept to 15 bits
  function automatic logic [CENTI_W-1:0] scale_centi(input logic [PROD_W-1:0] prod,
                                                     input logic [WORD_W-1:0] offset);
    logic [PROD_W:0]   sum;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] s;
    sum = {1'b0, prod} + {17'd0, prod[PROD_W-1:WORD_W]} + {{PROD_W{1'b0}}, 1'b1};
    q   = sum[PROD_W:WORD_W];
    s   = q - offset;
    return s[CENTI_W-1:0];
  endfunction

endpackage

// ===== sv/humidity_temp_frame_decoder.sv =====
// measurement frame decoder: byte stream in, crc-checked scaled readings out
// depends on htfd_pkg
//
//  channel   dir  payload
//  s_axis    in   tdata: data_byte; tuser: frame_start
//  m_axis    out  tdata: temp_centi, humid_centi, temp_raw, humid_raw, flags
//
// one byte per cycle unless stalled; a result beat in the cycle after the sixth byte
// word products are registered at the low word bytes, the divide by 65535
// and offset finish on the crc byte
// reset clears byte position, crc and output valid
// input stalls only while a result beat waits and m_axis_tready is low
module humidity_temp_frame_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [htfd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic [htfd_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // [0] frame_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [14:0] temp_centi, [29:15] humid_centi, [45:30] temp_raw, [61:46] humid_raw,
  // [62] temp_check_pass, [63] humid_check_pass, [64] frame_valid, [71:65] zero
  output logic [htfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import htfd_pkg::*;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0]             pos_q, pos_cur, pos_d;
  logic [BYTE_W-1:0]      crc_q, crc_d, crc_seed, crc_fed;
  logic [WORD_W-1:0]      temp_word_q, temp_word_d;
  logic [WORD_W-1:0]      humid_word_q, humid_word_d;
  logic                   temp_check_q, temp_check_d;
  logic [PROD_W-1:0]      temp_prod_q, humid_prod_q;
  logic [PROD_W-1:0]      temp_prod_d, humid_prod_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  logic [BYTE_W-1:0]      in_byte;
  logic                   accept;
  logic                   humid_pass;

  assign in_byte       = s_axis_tdata[BYTE_W-1:0];
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign pos_cur  = (s_axis_tuser[0] || (pos_q > POS_H_CRC)) ? POS_T_HI : pos_q;
  assign crc_seed = ((pos_cur == POS_T_HI) || (pos_cur == POS_H_HI)) ? CRC_INIT : crc_q;
  assign crc_fed  = crc8_feed(crc_seed, in_byte);
  assign humid_pass = (crc_q == in_byte);

  assign temp_prod_d  = PROD_W'({temp_word_q[WORD_W-1:BYTE_W], in_byte}) * PROD_W'(TEMP_SPAN);
  assign humid_prod_d = PROD_W'({humid_word_q[WORD_W-1:BYTE_W], in_byte}) * PROD_W'(HUMID_SPAN);

  always_comb begin
    pos_d        = pos_cur + 3'd1;
    crc_d        = crc_q;
    temp_word_d  = temp_word_q;
    humid_word_d = humid_word_q;
    temp_check_d = temp_check_q;
    unique case (pos_cur)
      POS_T_HI: begin
        crc_d       = crc_fed;
        temp_word_d = {in_byte, BYTE_W'(0)};
      end
      POS_T_LO: begin
        crc_d       = crc_fed;
        temp_word_d = {temp_word_q[WORD_W-1:BYTE_W], in_byte};
      end
      POS_T_CRC: begin
        temp_check_d = (crc_q == in_byte);
        crc_d        = CRC_INIT;
      end
      POS_H_HI: begin
        crc_d        = crc_fed;
        humid_word_d = {in_byte, BYTE_W'(0)};
      end
      POS_H_LO: begin
        crc_d        = crc_fed;
        humid_word_d = {humid_word_q[WORD_W-1:BYTE_W], in_byte};
      end
      default: begin
        crc_d = CRC_INIT;
        pos_d = POS_T_HI;
      end
    endcase
  end

  always_comb begin
    m_data_d = '0;
    m_data_d[TC_LSB +: CENTI_W] = scale_centi(temp_prod_q, TEMP_OFFSET);
    m_data_d[HC_LSB +: CENTI_W] = scale_centi(humid_prod_q, HUMID_OFFSET);
    m_data_d[TR_LSB +: WORD_W]  = temp_word_q;
    m_data_d[HR_LSB +: WORD_W]  = humid_word_q;
    m_data_d[TP_BIT]            = temp_check_q;
    m_data_d[HP_BIT]            = humid_pass;
    m_data_d[FV_BIT]            = temp_check_q && humid_pass;
  end

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    if (accept && (pos_cur == POS_H_CRC)) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_T_HI;
      crc_q        <= CRC_INIT;
      temp_word_q  <= '0;
      humid_word_q <= '0;
      temp_check_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      if (accept) begin
        pos_q        <= pos_d;
        crc_q        <= crc_d;
        temp_word_q  <= temp_word_d;
        humid_word_q <= humid_word_d;
        temp_check_q <= temp_check_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (pos_cur == POS_T_LO)) begin
      temp_prod_q <= temp_prod_d;
    end
    if (accept && (pos_cur == POS_H_LO)) begin
      humid_prod_q <= humid_prod_d;
    end
    if (accept && (pos_cur == POS_H_CRC)) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

// ===== sv/htfd_checker.sv =====
// port-level checker for the measurement frame decoder, bound to the top level
// depends on htfd_pkg and humidity_temp_frame_decoder_defines.svh
`include "humidity_temp_frame_decoder_defines.svh"

module htfd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  // [14:0] temp_centi, [29:15] humid_centi, [45:30] temp_raw, [61:46] humid_raw,
  // [62] temp_check_pass, [63] humid_check_pass, [64] frame_valid
  input logic [htfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import htfd_pkg::*;

  logic signed [CENTI_W-1:0] temp_centi;
  logic signed [CENTI_W-1:0] humid_centi;
  logic                      in_beat;
  logic                      out_wait;
  logic                      flags_ok;
  logic                      temp_ok;
  logic                      humid_ok;
  logic                      centi_ok;

  assign temp_centi  = m_axis_tdata[TC_LSB +: CENTI_W];
  assign humid_centi = m_axis_tdata[HC_LSB +: CENTI_W];
  assign in_beat     = s_axis_tvalid && s_axis_tready;
  assign out_wait    = m_axis_tvalid && !m_axis_tready;
  assign flags_ok    = m_axis_tdata[FV_BIT] == (m_axis_tdata[TP_BIT] && m_axis_tdata[HP_BIT]);
  assign temp_ok     = (int'(temp_centi) >= TEMP_CENTI_MIN)
                       && (int'(temp_centi) <= TEMP_CENTI_MAX);
  assign humid_ok    = (int'(humid_centi) >= HUMID_CENTI_MIN)
                       && (int'(humid_centi) <= HUMID_CENTI_MAX);
  assign centi_ok    = temp_ok && humid_ok;

  `HTFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

  `HTFD_ASSERT_NOW(a_valid_and, clk_i, rst_ni, m_axis_tvalid, flags_ok)

  `HTFD_ASSERT_NOW(a_stall_back, clk_i, rst_ni, out_wait, !s_axis_tready)

  `HTFD_ASSERT_NOW(a_rise_cause, clk_i, rst_ni, $rose(m_axis_tvalid), $past(in_beat))

  `HTFD_ASSERT_NOW(a_centi_range, clk_i, rst_ni, m_axis_tvalid, centi_ok)

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

// ===== bench/htfd_reading_checker.sv =====
// frame decoder checker: tracks the byte stream, predicts each reading and
// compares it with the result beats; depends on htfd_pkg for the port widths
module htfd_reading_checker
  import htfd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,   // [0] frame_start
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // temp_centi .. frame_valid, pad
  output int                     error_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CRC_SEED  = 8'hFF;
  localparam logic [7:0] CRC_GEN   = 8'h31;
  localparam int unsigned T_SPAN   = 17500;
  localparam int unsigned T_OFS    = 4500;
  localparam int unsigned H_SPAN   = 12500;
  localparam int unsigned H_OFS    = 600;
  localparam int unsigned RAW_FULL = 65535;

  typedef enum logic [2:0] {
    POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO, POS_H_CRC
  } frame_pos_e;

  // lowest field last, matches the result beat layout
  typedef struct packed {
    logic [6:0]                pad;
    logic                      frame_valid;
    logic                      humid_check_pass;
    logic                      temp_check_pass;
    logic [WORD_W-1:0]         humid_raw;
    logic [WORD_W-1:0]         temp_raw;
    logic signed [CENTI_W-1:0] humid_centi;
    logic signed [CENTI_W-1:0] temp_centi;
  } reading_t;

  reading_t   expected_readings_q[$];
  frame_pos_e pos;
  logic [7:0] crc_acc;
  logic [WORD_W-1:0] t_word, h_word;
  logic       t_ok;
  int         n_err = 0;

  assign error_count_o = n_err;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) v = {v[6:0], 1'b0} ^ CRC_GEN;
      else      v = {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [CENTI_W-1:0] to_centi(input logic [WORD_W-1:0] raw,
                                                  input int unsigned span,
                                                  input int unsigned ofs);
    longint q;
    q = (longint'(raw) * longint'(span)) / longint'(RAW_FULL) - longint'(ofs);
    return q[CENTI_W-1:0];
  endfunction

  function automatic void check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      n_err++;
      $error("%s: expected %0d, got %0d", name, e, a);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    reading_t   exp_r;
    reading_t   got;
    frame_pos_e p;
    logic [7:0] b;
    if (!rst_ni) begin
      pos     = POS_T_HI;
      crc_acc = CRC_SEED;
      t_word  = '0;
      h_word  = '0;
      t_ok    = 1'b0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (expected_readings_q.size() == 0) begin
          n_err++;
          $error("result beat with no reading expected: %h", m_axis_tdata_i);
        end else begin
          exp_r = expected_readings_q.pop_front();
          check_field("temp_centi", exp_r.temp_centi, got.temp_centi);
          check_field("humid_centi", exp_r.humid_centi, got.humid_centi);
          check_field("temp_raw", exp_r.temp_raw, got.temp_raw);
          check_field("humid_raw", exp_r.humid_raw, got.humid_raw);
          check_field("temp_check_pass", exp_r.temp_check_pass, got.temp_check_pass);
          check_field("humid_check_pass", exp_r.humid_check_pass, got.humid_check_pass);
          check_field("frame_valid", exp_r.frame_valid, got.frame_valid);
          check_field("pad", exp_r.pad, got.pad);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        b = s_axis_tdata_i[7:0];
        p = s_axis_tuser_i[0] ? POS_T_HI : pos;
        case (p)
          POS_T_HI: begin
            crc_acc = crc_step(CRC_SEED, b);
            t_word  = {b, 8'h00};
          end
          POS_T_LO: begin
            crc_acc     = crc_step(crc_acc, b);
            t_word[7:0] = b;
          end
          POS_T_CRC: begin
            t_ok    = (crc_acc == b);
            crc_acc = CRC_SEED;
          end
          POS_H_HI: begin
            crc_acc = crc_step(CRC_SEED, b);
            h_word  = {b, 8'h00};
          end
          POS_H_LO: begin
            crc_acc     = crc_step(crc_acc, b);
            h_word[7:0] = b;
          end
          default: begin
            exp_r                  = '0;
            exp_r.temp_centi       = to_centi(t_word, T_SPAN, T_OFS);
            exp_r.humid_centi      = to_centi(h_word, H_SPAN, H_OFS);
            exp_r.temp_raw         = t_word;
            exp_r.humid_raw        = h_word;
            exp_r.temp_check_pass  = t_ok;
            exp_r.humid_check_pass = (crc_acc == b);
            exp_r.frame_valid      = t_ok && (crc_acc == b);
            crc_acc                = CRC_SEED;
            expected_readings_q.push_back(exp_r);
          end
        endcase
        pos = (p == POS_H_CRC) ? POS_T_HI : frame_pos_e'(p + 1);
      end
    end
    pending_o = expected_readings_q.size();
  end

endmodule

// ===== bench/tb_humidity_temp_frame_decoder.sv =====
// frame decoder testbench top: clock, reset, byte stream stimulus and verdict
// depends on htfd_pkg, humidity_temp_frame_decoder and htfd_reading_checker
module tb_humidity_temp_frame_decoder;
  import htfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS = 1150;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tready = 1'b0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;

  int src_idle_pct = 16;
  int sink_idle_pct = 63;
  int n_sent = 0;
  int n_err;
  int n_pending;

  humidity_temp_frame_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  htfd_reading_checker reading_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .error_count_o   (n_err),
    .pending_o       (n_pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // frame crc over one word, high byte first
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] v;
    v = 8'hFF;
    for (int i = 1; i >= 0; i--) begin
      v = v ^ w[i*8 +: 8];
      for (int k = 0; k < 8; k++) begin
        if (v[7]) v = {v[6:0], 1'b0} ^ 8'h31;
        else      v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic mark);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mark;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input logic t_bad, input logic h_bad, input logic mark);
    logic [7:0] tc, hc;
    tc = word_crc(tw) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
    hc = word_crc(hw) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
    send_beat(tw[15:8], mark);
    send_beat(tw[7:0], 1'b0);
    send_beat(tc, 1'b0);
    send_beat(hw[15:8], 1'b0);
    send_beat(hw[7:0], 1'b0);
    send_beat(hc, 1'b0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
  endtask

  task automatic random_seq();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 80) begin
      send_frame(pick_word(), pick_word(), $urandom_range(9) == 0,
                 $urandom_range(9) == 0, 1'($urandom_range(1)));
    end else if (kind < 90) begin
      // truncated frame, the next marked beat restarts
      n = $urandom_range(1, 5);
      send_beat(8'($urandom_range(255)), 1'b1);
      repeat (n - 1) send_beat(8'($urandom_range(255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 6)) send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unmarked frame right after reset, extreme words
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1);
    // partial frame dropped by a restart
    send_beat(8'h5A, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 16; sink_idle_pct = 63; end
        1: begin src_idle_pct = 63; sink_idle_pct = 16; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      while (n_sent < N_ITEMS * (ph + 1) / 3) random_seq();
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
